### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the scan sequencer.
// No dependencies; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define ASA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: required property does not hold");
// Check that a condition never occurs outside reset.
`define ASA_NEVER(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("assertion failed: forbidden condition occurred");
`else
`define ASA_ASSERT(label, clk, rst_n, prop)
`define ASA_NEVER(label, clk, rst_n, prop)
`endif
`endif

### rtl/asa_pkg.sv
// Shared types, constants and helper functions of the ADC scan sequencer.
// No dependencies; imported by every module of the block.
package asa_pkg;

    localparam int HISTORY_DEPTH = 16;
    localparam int CHANNELS      = 8;

    localparam int CH_W        = 3;
    localparam int SAMPLE_W    = 10;
    localparam int PAT_W       = 24;
    localparam int LEN_W       = 4;
    localparam int MODE_W      = 2;
    localparam int POS_W       = 3;
    localparam int PAT_ENTRIES = 8;
    localparam int CFG_IDX_W   = 1;

    localparam int HIST_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W    = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W     = $clog2(HISTORY_DEPTH * 1023 + 1);
    localparam int ALU_W     = SUM_W + 1;
    localparam int DCNT_W    = $clog2(SUM_W + 1);
    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MEM_DEPTH = CHANNELS * HISTORY_DEPTH;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PATTERN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LENGTH  = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_CONV    = 2'd0,
        MODE_COLLECT = 2'd1,
        MODE_RESTART = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SUM,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    function automatic logic [CH_W-1:0] entry_at(input logic [PAT_W-1:0] pat,
                                                 input logic [POS_W-1:0] pos);
        logic [PAT_W-1:0] shifted;
        shifted = pat >> (5'(pos) * 5'd3);
        return shifted[CH_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] used_length(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        if (len == '0) begin
            res = LEN_W'(1);
        end else if (len > LEN_W'(PAT_ENTRIES)) begin
            res = LEN_W'(PAT_ENTRIES);
        end else begin
            res = len;
        end
        return res;
    endfunction

    function automatic logic chan_in_range(input logic [CH_W-1:0] ch);
        return ({1'b0, ch} < (CH_W + 1)'(CHANNELS));
    endfunction

    function automatic logic [MEM_AW-1:0] mem_addr(input logic [CH_W-1:0]   ch,
                                                   input logic [HIST_W-1:0] slot);
        return MEM_AW'(ch) * MEM_AW'(HISTORY_DEPTH) + MEM_AW'(slot);
    endfunction

endpackage

### rtl/asa_sample_ram.sv
// Sample history memory: one ring of HISTORY_DEPTH slots per channel.
// Depends on asa_pkg; one write port, one read port with registered data.
module asa_sample_ram (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [asa_pkg::MEM_AW-1:0]    waddr,
    input  logic [asa_pkg::SAMPLE_W-1:0]  wdata,
    input  logic                          re,
    input  logic [asa_pkg::MEM_AW-1:0]    raddr,
    output logic [asa_pkg::SAMPLE_W-1:0]  rdata
);
    import asa_pkg::*;

    logic [SAMPLE_W-1:0] mem [MEM_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/asa_alu.sv
// Shared add/subtract unit used for accumulation and for restoring division.
// Depends on asa_pkg for the request struct and width.
module asa_alu (
    input  asa_pkg::alu_req_t         req,
    output logic [asa_pkg::ALU_W-1:0] result
);
    import asa_pkg::*;

    logic [ALU_W-1:0] b_eff;

    // Subtract as add of the inverted operand plus one.
    assign b_eff  = req.sub ? ~req.b : req.b;
    assign result = req.a + b_eff + ALU_W'(req.sub);

endmodule

### rtl/adc_scan_sequencer_averager.sv
// Top level of the ADC scan sequencer with per-channel history averaging.
// Depends on asa_pkg, asa_alu, asa_sample_ram and assert_macros.svh.
//
// Input items (s_valid/s_ready) carry a mode: conversion finished (s_sample
// is stored for the channel at the current pattern entry, then the pattern
// advances), collect (average of s_channel's history, then empty it), or
// restart (pattern back to entry 0, all histories emptied). Every item yields
// exactly one result item on m_valid/m_ready with the channel to convert next,
// a found flag and the truncated average. Configuration (cfg_we/cfg_index/
// cfg_wdata) sets the packed pattern and its length; write it only while idle.
// Timing: one item at a time, s_ready is high only in idle. A conversion,
// restart or empty collect goes through the execute and finish states to the
// output register; the next item is taken once the block is back in idle. A
// collect of n samples sums them, one memory read per cycle feeding the
// shared adder, then the same adder runs a restoring division, one quotient
// bit per cycle.
// Reset (aresetn, synchronous) clears the pattern to zero, length to 1, the
// position and all history counts; sample memory is not cleared. A result is
// held in the output register while m_ready is low; one more item may be
// accepted meanwhile, and its result waits until the held one is taken.
`include "assert_macros.svh"

module adc_scan_sequencer_averager (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [asa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [asa_pkg::PAT_W-1:0]      cfg_wdata,
    // input item channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [asa_pkg::MODE_W-1:0]     s_mode,
    input  logic [asa_pkg::SAMPLE_W-1:0]   s_sample,
    input  logic [asa_pkg::CH_W-1:0]       s_channel,
    // result item channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [asa_pkg::CH_W-1:0]       m_next_channel,
    output logic                           m_found,
    output logic [asa_pkg::SAMPLE_W-1:0]   m_average
);
    import asa_pkg::*;

    // sequencer and control state
    state_t              state_reg, state_next;
    logic [PAT_W-1:0]    pat_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [HIST_W-1:0]   wp_reg   [CHANNELS];
    logic [FILL_W-1:0]   fill_reg [CHANNELS];
    logic                rd_pend_reg;
    logic                m_valid_reg;

    // item payload and working registers
    logic [MODE_W-1:0]   mode_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [CH_W-1:0]     cur_ch_reg;
    logic [FILL_W-1:0]   n_reg;
    logic [FILL_W-1:0]   idx_reg;
    logic [SUM_W-1:0]    dvd_reg;
    logic [FILL_W-1:0]   rem_reg;
    logic [DCNT_W-1:0]   dcnt_reg;
    logic                found_reg;
    logic [CH_W-1:0]     m_next_channel_reg;
    logic                m_found_reg;
    logic [SAMPLE_W-1:0] m_average_reg;

    // derived signals
    logic                accept;
    logic                ch_ok;
    logic [CH_IDX_W-1:0] cur_idx;
    logic [HIST_W-1:0]   wp_cur;
    logic [FILL_W-1:0]   fill_cur;
    logic [HIST_W-1:0]   wp_inc;
    logic [FILL_W-1:0]   fill_inc;
    logic [POS_W:0]      pos_p1;
    logic [POS_W-1:0]    pos_adv;
    logic                collect_hit;
    logic [FILL_W:0]     rem_sh;
    logic                borrow;

    // control outputs of the sequencer
    logic                mem_we;
    logic                mem_re;
    logic                out_load;
    alu_req_t            alu_req;
    logic [ALU_W-1:0]    alu_res;
    logic [SAMPLE_W-1:0] mem_rdata;

    assign accept   = s_valid && s_ready;
    assign cur_idx  = cur_ch_reg[CH_IDX_W-1:0];
    assign ch_ok    = chan_in_range(cur_ch_reg);
    assign wp_cur   = wp_reg[cur_idx];
    assign fill_cur = fill_reg[cur_idx];

    // Wrap the ring pointer; saturate the fill count at the history depth.
    assign wp_inc   = (wp_cur == HIST_W'(HISTORY_DEPTH - 1)) ? '0 : wp_cur + 1'b1;
    assign fill_inc = (fill_cur < FILL_W'(HISTORY_DEPTH)) ? fill_cur + 1'b1 : fill_cur;

    // Advance the pattern, wrapping once the position reaches the used length.
    assign pos_p1  = {1'b0, pos_reg} + 1'b1;
    assign pos_adv = (pos_p1 >= used_length(len_reg)) ? '0 : pos_p1[POS_W-1:0];

    assign collect_hit = (mode_reg == MODE_COLLECT) && ch_ok && (fill_cur != '0);

    // Restoring division step: shift in the next dividend bit, try subtract.
    assign rem_sh = {rem_reg, dvd_reg[SUM_W-1]};
    assign borrow = alu_res[ALU_W-1];

    asa_alu u_alu (
        .req    (alu_req),
        .result (alu_res)
    );

    asa_sample_ram u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_addr(cur_ch_reg, wp_cur)),
        .wdata (sample_reg),
        .re    (mem_re),
        .raddr (mem_addr(cur_ch_reg, idx_reg[HIST_W-1:0])),
        .rdata (mem_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = collect_hit ? ST_SUM : ST_FINISH;
            end
            ST_SUM: begin
                if ((idx_reg == n_reg) && !rd_pend_reg) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (dcnt_reg == DCNT_W'(SUM_W - 1)) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready  = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        out_load = 1'b0;
        alu_req  = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_EXEC: begin
                mem_we = (mode_reg == MODE_CONV) && ch_ok;
            end
            ST_SUM: begin
                mem_re      = (idx_reg != n_reg);
                alu_req.a   = ALU_W'(dvd_reg);
                alu_req.b   = ALU_W'(mem_rdata);
                alu_req.sub = 1'b0;
            end
            ST_DIV: begin
                alu_req.a   = ALU_W'(rem_sh);
                alu_req.b   = ALU_W'(n_reg);
                alu_req.sub = 1'b1;
            end
            ST_FINISH: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // control state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pat_reg     <= '0;
            len_reg     <= LEN_W'(1);
            pos_reg     <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                wp_reg[i]   <= '0;
                fill_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= mem_re;

            if (cfg_we) begin
                case (cfg_index)
                    CFG_IDX_PATTERN: pat_reg <= cfg_wdata;
                    CFG_IDX_LENGTH:  len_reg <= cfg_wdata[LEN_W-1:0];
                    default:         pat_reg <= pat_reg;
                endcase
            end

            if (state_reg == ST_EXEC) begin
                case (mode_reg)
                    MODE_CONV: begin
                        if (ch_ok) begin
                            wp_reg[cur_idx]   <= wp_inc;
                            fill_reg[cur_idx] <= fill_inc;
                        end
                        pos_reg <= pos_adv;
                    end
                    MODE_COLLECT: begin
                        // empty the history; the sum uses the count held in n_reg
                        if (collect_hit) begin
                            wp_reg[cur_idx]   <= '0;
                            fill_reg[cur_idx] <= '0;
                        end
                    end
                    MODE_RESTART: begin
                        pos_reg <= '0;
                        for (int i = 0; i < CHANNELS; i++) begin
                            wp_reg[i]   <= '0;
                            fill_reg[i] <= '0;
                        end
                    end
                    default: begin
                        pos_reg <= pos_reg;
                    end
                endcase
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg   <= s_mode;
            sample_reg <= s_sample;
            // conversions target the channel at the current pattern entry
            cur_ch_reg <= (s_mode == MODE_CONV) ? entry_at(pat_reg, pos_reg) : s_channel;
        end

        case (state_reg)
            ST_EXEC: begin
                n_reg     <= fill_cur;
                idx_reg   <= '0;
                dvd_reg   <= '0;
                rem_reg   <= '0;
                dcnt_reg  <= '0;
                found_reg <= collect_hit;
            end
            ST_SUM: begin
                if (mem_re) idx_reg <= idx_reg + 1'b1;
                if (rd_pend_reg) dvd_reg <= alu_res[SUM_W-1:0];
            end
            ST_DIV: begin
                dvd_reg  <= {dvd_reg[SUM_W-2:0], ~borrow};
                rem_reg  <= borrow ? rem_sh[FILL_W-1:0] : alu_res[FILL_W-1:0];
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            default: begin
                idx_reg <= idx_reg;
            end
        endcase

        if (out_load) begin
            m_next_channel_reg <= entry_at(pat_reg, pos_reg);
            m_found_reg        <= found_reg;
            m_average_reg      <= found_reg ? dvd_reg[SAMPLE_W-1:0] : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_next_channel = m_next_channel_reg;
    assign m_found        = m_found_reg;
    assign m_average      = m_average_reg;

    `ASA_ASSERT(a_accept_starts_exec, aclk, aresetn, s_valid && s_ready |=> state_reg == ST_EXEC)
    `ASA_ASSERT(a_sum_index_bound, aclk, aresetn, state_reg == ST_SUM |-> idx_reg <= n_reg)
    `ASA_ASSERT(a_div_rem_bound, aclk, aresetn, state_reg == ST_DIV |-> rem_reg < n_reg)
    `ASA_ASSERT(a_fill_cap, aclk, aresetn, state_reg == ST_EXEC |-> fill_cur <= FILL_W'(HISTORY_DEPTH))
    `ASA_NEVER(a_no_result_overwrite, aclk, aresetn, out_load && m_valid_reg && !m_ready)

endmodule

### verif/adc_scan_sequencer_averager_test.sv
// Self-checking testbench for adc_scan_sequencer_averager: drives conversion, collect,
// restart and unused-mode items under random idling and checks every result item.
// Depends on asa_pkg and the RTL of the block; needs no files or arguments.
module adc_scan_sequencer_averager_test;
    import asa_pkg::*;

    // Mode code that the block must ignore: it only reports the current entry.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_TIME  = 40;
    localparam int PHASE_ITEMS  = 153;
    localparam int PHASES       = 10;
    localparam int LONG_HOLD    = 300;

    // Pattern entry k holds channel k.
    localparam logic [PAT_W-1:0] PAT_ASCENDING = 24'hFAC688;

    typedef struct {
        logic [CH_W-1:0]     next_channel;
        logic                found;
        logic [SAMPLE_W-1:0] average;
    } scan_result_t;

    // Scan and history model plus the queue of results it has promised.
    class scan_scoreboard;
        logic [PAT_W-1:0]    pattern;
        logic [LEN_W-1:0]    pat_len;
        logic [SAMPLE_W-1:0] history [CHANNELS][HISTORY_DEPTH];
        logic [HIST_W-1:0]   slot [CHANNELS];
        logic [FILL_W-1:0]   fill [CHANNELS];
        logic [POS_W-1:0]    position;
        scan_result_t        expected_q [$];
        int                  failures;

        function new();
            pattern  = '0;
            pat_len  = LEN_W'(1);
            position = '0;
            failures = 0;
            forget_histories();
        endfunction

        function void forget_histories();
            for (int c = 0; c < CHANNELS; c++) begin
                slot[c] = '0;
                fill[c] = '0;
            end
        endfunction

        function logic [CH_W-1:0] entry_of(logic [POS_W-1:0] pos);
            return pattern[CH_W*pos +: CH_W];
        endfunction

        // Length zero acts as one, anything above eight as eight.
        function int span();
            if (pat_len == 0) return 1;
            if (pat_len > PAT_ENTRIES) return PAT_ENTRIES;
            return int'(pat_len);
        endfunction

        function void set_config(logic [CFG_IDX_W-1:0] idx, logic [PAT_W-1:0] data);
            if (idx == CFG_IDX_PATTERN) begin
                pattern = data;
            end else if (idx == CFG_IDX_LENGTH) begin
                pat_len = data[LEN_W-1:0];
            end
        endfunction

        function void note_input(logic [MODE_W-1:0] mode, logic [SAMPLE_W-1:0] value,
                                 logic [CH_W-1:0] chan);
            scan_result_t want;
            int conv;
            int n;
            int sum;
            want.found   = 1'b0;
            want.average = '0;
            case (mode)
                MODE_CONV: begin
                    conv = int'(entry_of(position));
                    if (conv < CHANNELS) begin
                        history[conv][slot[conv]] = value;
                        slot[conv] = HIST_W'((int'(slot[conv]) + 1) % HISTORY_DEPTH);
                        if (fill[conv] < HISTORY_DEPTH) fill[conv] = fill[conv] + 1'b1;
                    end
                    // wrap also covers a position left beyond a shortened length
                    if (int'(position) + 1 >= span()) begin
                        position = '0;
                    end else begin
                        position = position + 1'b1;
                    end
                end
                MODE_COLLECT: begin
                    if (int'(chan) < CHANNELS && fill[chan] != 0) begin
                        n   = int'(fill[chan]);
                        sum = 0;
                        for (int i = 0; i < n; i++) sum += int'(history[chan][i]);
                        want.found   = 1'b1;
                        want.average = SAMPLE_W'(sum / n);
                        fill[chan]   = '0;
                        slot[chan]   = '0;
                    end
                end
                MODE_RESTART: begin
                    position = '0;
                    forget_histories();
                end
                default: begin
                end
            endcase
            want.next_channel = entry_of(position);
            expected_q.push_back(want);
        endfunction

        function void check_result(logic [CH_W-1:0] nxt, logic found,
                                   logic [SAMPLE_W-1:0] avg);
            scan_result_t want;
            if (expected_q.size() == 0) begin
                failures++;
                $display("%0t: unexpected result item: expected none, actual %0d/%0d/%0d",
                         $time, nxt, found, avg);
                return;
            end
            want = expected_q.pop_front();
            if (nxt !== want.next_channel) begin
                failures++;
                $display("%0t: next_channel mismatch: expected %0d, actual %0d",
                         $time, want.next_channel, nxt);
            end
            if (found !== want.found) begin
                failures++;
                $display("%0t: found mismatch: expected %0d, actual %0d",
                         $time, want.found, found);
            end
            if (avg !== want.average) begin
                failures++;
                $display("%0t: average mismatch: expected %0d, actual %0d",
                         $time, want.average, avg);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PAT_W-1:0]     cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [MODE_W-1:0]    s_mode    = '0;
    logic [SAMPLE_W-1:0]  s_sample  = '0;
    logic [CH_W-1:0]      s_channel = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [CH_W-1:0]      m_next_channel;
    logic                 m_found;
    logic [SAMPLE_W-1:0]  m_average;

    scan_scoreboard sb = new();

    int cycle_count   = 0;
    int items_sent    = 0;
    int rx_hold_cycles = 0;
    bit tx_idles      = 1'b1;
    bit rx_idles      = 1'b1;

    logic [PAT_W-1:0] phase_pat [PHASES];
    logic [LEN_W-1:0] phase_len [PHASES];

    adc_scan_sequencer_averager dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_sample       (s_sample),
        .s_channel      (s_channel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_next_channel (m_next_channel),
        .m_found        (m_found),
        .m_average      (m_average)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Stop a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Check every result item taken at this edge; values are those seen by the block.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_next_channel, m_found, m_average);
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(int shortest);
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return shortest;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Bias toward the sample extremes so the sums hit their corners.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        return SAMPLE_W'($urandom_range(0, 1023));
    endfunction

    // Receiver: random stalls, plus a long hold when the main sequence requests one.
    initial begin
        forever begin
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end else if (!rx_idles || $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat (pick_gap(1)) @(posedge aclk);
            end
        end
    end

    // Offer one item and hold it until taken; valid stays high across back-to-back items.
    task automatic send_item(logic [MODE_W-1:0] mode, logic [SAMPLE_W-1:0] value,
                             logic [CH_W-1:0] chan);
        int gap;
        gap = tx_idles ? pick_gap(0) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_mode    <= mode;
        s_sample  <= value;
        s_channel <= chan;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(mode, value, chan);
        items_sent++;
    endtask

    // Drop valid and wait until every promised result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Write both registers on consecutive edges; the block must be idle.
    task automatic configure(logic [PAT_W-1:0] pat, logic [LEN_W-1:0] len);
        logic [PAT_W-1:0] len_word;
        len_word = PAT_W'($urandom());
        len_word[LEN_W-1:0] = len;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_PATTERN;
        cfg_wdata <= pat;
        @(posedge aclk);
        sb.set_config(CFG_IDX_PATTERN, pat);
        cfg_index <= CFG_IDX_LENGTH;
        cfg_wdata <= len_word;
        @(posedge aclk);
        sb.set_config(CFG_IDX_LENGTH, len_word);
        cfg_we    <= 1'b0;
    endtask

    // Hand-picked corners on the reset configuration: every conversion lands on channel 0.
    task automatic run_directed();
        send_item(MODE_COLLECT, '0, '0);          // empty history: not found
        send_item(MODE_UNUSED, '1, '1);           // ignored mode
        repeat (17) send_item(MODE_CONV, '1, '0); // wrap the ring and saturate the count
        send_item(MODE_COLLECT, '0, '0);          // full history of maximum samples
        send_item(MODE_COLLECT, '1, '0);          // emptied by the previous collect
        send_item(MODE_CONV, '0, '1);
        send_item(MODE_CONV, 10'd513, '0);
        send_item(MODE_COLLECT, '0, '0);          // truncating mean
        send_item(MODE_RESTART, '1, '1);
    endtask

    // Mostly conversion runs and collects with random content, a little restart and noise.
    task automatic run_random(int count);
        int first;
        int r;
        first = items_sent;
        while (items_sent - first < count) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                repeat ($urandom_range(17, 24))
                    send_item(MODE_CONV, pick_sample(), CH_W'($urandom()));
            end else if (r < 66) begin
                send_item(MODE_CONV, pick_sample(), CH_W'($urandom()));
            end else if (r < 88) begin
                send_item(MODE_COLLECT, SAMPLE_W'($urandom()), CH_W'($urandom()));
            end else if (r < 92) begin
                for (int c = 0; c < CHANNELS; c++)
                    send_item(MODE_COLLECT, SAMPLE_W'($urandom()), CH_W'(c));
            end else if (r < 95) begin
                send_item(MODE_RESTART, SAMPLE_W'($urandom()), CH_W'($urandom()));
            end else begin
                send_item(MODE_UNUSED, SAMPLE_W'($urandom()), CH_W'($urandom()));
            end
        end
    endtask

    initial begin
        // Settings run through the extremes: length zero, too large, one and eight.
        phase_pat = '{PAT_ASCENDING, PAT_W'($urandom()), 24'hFFFFFF, PAT_W'($urandom()),
                      PAT_W'($urandom()), 24'h000000, PAT_W'($urandom()), PAT_W'($urandom()),
                      PAT_ASCENDING, PAT_W'($urandom())};
        phase_len = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd8, 4'd1, 4'd9,
                      LEN_W'($urandom_range(1, 8)), 4'd5, 4'd2};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();
        drain();

        for (int p = 0; p < PHASES; p++) begin
            configure(phase_pat[p], phase_len[p]);
            // Leave some phases free of idling on one side or both.
            tx_idles = ($urandom_range(0, 3) != 0);
            rx_idles = ($urandom_range(0, 3) != 0);
            if (p == 4) begin
                // Hold the receiver while the sender keeps offering, then pause the sender.
                run_random(PHASE_ITEMS / 2);
                rx_hold_cycles = LONG_HOLD;
                run_random(30);
                drain();
                run_random(PHASE_ITEMS - PHASE_ITEMS / 2 - 30);
            end else begin
                run_random(PHASE_ITEMS);
            end
            // Park the position high so the next, shorter length starts beyond its end.
            if (p == 2) begin
                while (sb.position < 5) send_item(MODE_CONV, pick_sample(), CH_W'($urandom()));
            end
            drain();
        end

        repeat (SETTLE_TIME) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
